// ===== rtl/som_pkg.sv =====
// Package: types, constants and codes shared by the map engine files
package som_pkg;
  localparam int GRID_ROWS_D  = 8;
  localparam int GRID_COLS_D  = 8;
  localparam int VECTOR_LEN_D = 2;

  typedef enum logic [2:0] {
    FN_LOAD     = 3'd0,
    FN_TRAIN    = 3'd1,
    FN_COUNT    = 3'd2,
    FN_FINALIZE = 3'd3,
    FN_CLASSIFY = 3'd4
  } func_t;

  localparam logic [1:0] KIND_TRAIN    = 2'd0;
  localparam logic [1:0] KIND_COUNT    = 2'd1;
  localparam logic [1:0] KIND_CLASSIFY = 2'd2;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [15:0] value;
    logic               last;
    logic [2:0]         target_row;
    logic [2:0]         target_col;
    logic [3:0]         element_index;
    logic [15:0]        rate;
    logic [2:0]         radius;
    logic               class_bit;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [2:0]  winner_row;
    logic [2:0]  winner_col;
    logic [37:0] min_distance;
    logic        label;
  } out_word_t;

  // Command handed from front to back
  typedef enum logic [2:0] {
    CMD_LOAD, CMD_FINALIZE, CMD_TRAIN, CMD_COUNT, CMD_CLASSIFY
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t            op;
    logic signed [15:0] value;
    logic [4:0]         row;
    logic [4:0]         col;
    logic [3:0]         eidx;
    logic [15:0]        rate;
    logic [2:0]         radius;
    logic               class_bit;
  } cmd_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_SRCH, BK_SRCH_ACC, BK_DECIDE, BK_TRN_RD, BK_TRN_MUL, BK_TRN_WR,
    BK_CNT_RD, BK_CNT_WR, BK_FIN, BK_OUT
  } back_state_t;
endpackage

// ===== rtl/self_organizing_map_engine.sv =====
// Top level of the self-organizing map engine
//   channel  dir  handshake          word
//   in_      in   in_valid/in_stall  in_word_t
//   out_     out  out_valid/out_stall out_word_t
// Load writes one weight element; a pattern's last element starts a winner search
// over N neurons (one weight memory read port), then for training a read, multiply
// and write per weight element of the window. Finalize walks the N counters, one a cycle.
// Element words stall while any command is queued or the back end is busy.
// Reset clears control, labels and counter valid bits at once.
// The output register lets the back end keep going while a result is stalled.
module self_organizing_map_engine import som_pkg::*; #(
  parameter int GRID_ROWS  = GRID_ROWS_D,
  parameter int GRID_COLS  = GRID_COLS_D,
  parameter int VECTOR_LEN = VECTOR_LEN_D,
  localparam int EW = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);
  logic cmd_valid, q_full, q_empty, q_pop, back_busy, pat_busy;
  cmd_t cmd, q_head;
  logic [EW-1:0] pat_raddr;
  logic signed [15:0] pat_rdata;

  assign pat_busy = back_busy || !q_empty;

  som_front #(.VECTOR_LEN(VECTOR_LEN), .GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_word, .cmd_valid, .cmd_full(q_full),
    .pat_busy, .cmd, .pat_raddr, .pat_rdata);

  som_queue u_queue (.clk, .rst_n, .push(cmd_valid), .push_cmd(cmd), .full(q_full),
    .pop(q_pop), .empty(q_empty), .head(q_head));

  som_back #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS), .VECTOR_LEN(VECTOR_LEN)) u_back (
    .clk, .rst_n, .q_empty, .q_head, .q_pop, .busy(back_busy), .pat_raddr, .pat_rdata,
    .out_valid, .out_stall, .out_word);
endmodule

// ===== rtl/som_front.sv =====
// Front end: accepts words, buffers pattern elements, issues commands
module som_front import som_pkg::*; #(
  parameter int VECTOR_LEN = VECTOR_LEN_D,
  parameter int GRID_ROWS  = GRID_ROWS_D,
  parameter int GRID_COLS  = GRID_COLS_D,
  localparam int EW = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        cmd_valid,
  input  logic        cmd_full,
  input  logic        pat_busy,
  output cmd_t        cmd,
  input  logic [EW-1:0] pat_raddr,
  output logic signed [15:0] pat_rdata
);
  logic signed [15:0] pat_r [VECTOR_LEN];
  logic [EW-1:0] cnt_r, cnt_nxt;
  logic acc, elem, issue;

  // hold all words while the queue is full, element words while any command waits or runs
  assign in_stall = cmd_full || (elem && pat_busy);
  assign acc = in_valid && !in_stall;
  assign elem = (in_word.func == FN_TRAIN) || (in_word.func == FN_COUNT) ||
                (in_word.func == FN_CLASSIFY);
  assign pat_rdata = pat_r[pat_raddr];

  always_comb begin
    cmd = '0;
    cmd.value = in_word.value;
    cmd.row = {2'b0, in_word.target_row};
    cmd.col = {2'b0, in_word.target_col};
    cmd.eidx = in_word.element_index;
    cmd.rate = in_word.rate;
    cmd.radius = in_word.radius;
    cmd.class_bit = in_word.class_bit;
    issue = 1'b0;
    cnt_nxt = cnt_r;
    case (in_word.func)
      FN_LOAD: begin
        cmd.op = CMD_LOAD;
        issue = (32'(in_word.target_row) < GRID_ROWS) && (32'(in_word.target_col) < GRID_COLS)
                && (32'(in_word.element_index) < VECTOR_LEN);
      end
      FN_FINALIZE: begin
        cmd.op = CMD_FINALIZE;
        issue = 1'b1;
      end
      FN_TRAIN:    cmd.op = CMD_TRAIN;
      FN_COUNT:    cmd.op = CMD_COUNT;
      FN_CLASSIFY: cmd.op = CMD_CLASSIFY;
      default:     cmd.op = CMD_LOAD;
    endcase
    if (elem) begin
      issue = in_word.last;
      if (in_word.last) cnt_nxt = '0;
      else if (32'(cnt_r) < VECTOR_LEN - 1) cnt_nxt = cnt_r + 1'b1;
    end
    cmd_valid = acc && issue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (acc) begin
      cnt_r <= cnt_nxt;
    end
    if (acc && elem) pat_r[cnt_r] <= in_word.value;
  end
endmodule

// ===== rtl/som_queue.sv =====
// Short command queue between front and back
module som_queue import som_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);
  cmd_t mem_r [2];
  logic [1:0] wp_r, rp_r;
  assign full = (wp_r[0] == rp_r[0]) && (wp_r[1] != rp_r[1]);
  assign empty = wp_r == rp_r;
  assign head = mem_r[rp_r[0]];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop) rp_r <= rp_r + 2'd1;
    end
    if (push) mem_r[wp_r[0]] <= push_cmd;
  end
endmodule

// ===== rtl/som_back.sv =====
// Back end: winner search, neighborhood training, label counting
module som_back import som_pkg::*; #(
  parameter int GRID_ROWS  = GRID_ROWS_D,
  parameter int GRID_COLS  = GRID_COLS_D,
  parameter int VECTOR_LEN = VECTOR_LEN_D,
  localparam int EW = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1,
  localparam int NEUR = GRID_ROWS * GRID_COLS,
  localparam int NW = (NEUR > 1) ? $clog2(NEUR) : 1,
  localparam int WD = NEUR * VECTOR_LEN,
  localparam int WAW = (WD > 1) ? $clog2(WD) : 1
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  cmd_t        q_head,
  output logic        q_pop,
  output logic        busy,
  output logic [EW-1:0] pat_raddr,
  input  logic signed [15:0] pat_rdata,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word
);
  logic signed [15:0] wmem [WD];
  logic [15:0] cnt0 [NEUR];
  logic [15:0] cnt1 [NEUR];
  logic [NEUR-1:0] lab_r, lab_nxt, cval_r, cval_nxt;

  back_state_t st_r, st_nxt;
  cmd_t c_r, c_nxt;
  logic [4:0] r_r, r_nxt, c2_r, c2_nxt, r1_r, r1_nxt, c0_r, c0_nxt, c1_r, c1_nxt;
  logic [4:0] br_r, br_nxt, bc_r, bc_nxt;
  logic [EW-1:0] e_r, e_nxt;
  logic [NW-1:0] bn_r, bn_nxt, fn_r, fn_nxt;
  logic [37:0] d_r, d_nxt, bd_r, bd_nxt;
  logic signed [15:0] wq_r, pq_r;
  logic signed [33:0] prod_r;
  logic [15:0] k0_r, k1_r;
  logic ov_r, ov_nxt;
  out_word_t ow_r, ow_nxt;

  logic [NW-1:0] nidx, kidx;
  logic [WAW-1:0] waddr;
  logic we, cwe;
  logic signed [15:0] wnew;
  logic signed [16:0] diff;
  logic [37:0] dsum;
  logic signed [33:0] rnd;
  logic signed [17:0] wsum;
  logic [5:0] rhi, chi;

  assign nidx = NW'(32'(r_r) * GRID_COLS + 32'(c2_r));
  assign waddr = WAW'(32'(nidx) * VECTOR_LEN + 32'(e_r));
  assign pat_raddr = e_r;
  assign out_valid = ov_r;
  assign out_word = ow_r;
  assign busy = st_r != BK_IDLE;
  assign diff = 17'(pq_r) - 17'(wq_r);
  assign dsum = d_r + 38'(34'(diff) * 34'(diff));
  assign rnd = prod_r + 34'sd32768;
  assign wsum = 18'(wq_r) + 18'(rnd >>> 16);

  always_comb begin
    st_nxt = st_r; c_nxt = c_r; r_nxt = r_r; c2_nxt = c2_r; r1_nxt = r1_r;
    c0_nxt = c0_r; c1_nxt = c1_r; e_nxt = e_r; bn_nxt = bn_r; fn_nxt = fn_r;
    br_nxt = br_r; bc_nxt = bc_r;
    d_nxt = d_r; bd_nxt = bd_r; ov_nxt = ov_r; ow_nxt = ow_r;
    lab_nxt = lab_r; cval_nxt = cval_r;
    q_pop = 1'b0; we = 1'b0; cwe = 1'b0; wnew = q_head.value;
    rhi = '0; chi = '0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (st_r)
      BK_IDLE: if (!q_empty) begin
        q_pop = 1'b1;
        c_nxt = q_head;
        case (q_head.op)
          CMD_LOAD: begin
            we = 1'b1;
          end
          CMD_FINALIZE: begin
            fn_nxt = '0;
            st_nxt = BK_FIN;
          end
          default: begin
            r_nxt = '0; c2_nxt = '0; e_nxt = '0; d_nxt = '0; fn_nxt = '0;
            st_nxt = BK_SRCH;
          end
        endcase
      end
      BK_SRCH: st_nxt = BK_SRCH_ACC;
      BK_SRCH_ACC: begin
        d_nxt = dsum;
        if (32'(e_r) == VECTOR_LEN - 1) begin
          e_nxt = '0;
          st_nxt = BK_DECIDE;
        end else begin
          e_nxt = e_r + 1'b1;
          st_nxt = BK_SRCH;
        end
      end
      BK_DECIDE: begin
        if (fn_r == '0 || d_r < bd_r) begin
          bd_nxt = d_r; bn_nxt = fn_r; br_nxt = r_r; bc_nxt = c2_r;
        end
        d_nxt = '0;
        if (32'(fn_r) == NEUR - 1) begin
          case (c_r.op)
            CMD_TRAIN: begin
              rhi = {1'b0, br_nxt} + 6'(c_r.radius);
              chi = {1'b0, bc_nxt} + 6'(c_r.radius);
              r1_nxt = (32'(rhi) > GRID_ROWS - 1) ? 5'(GRID_ROWS - 1) : rhi[4:0];
              c1_nxt = (32'(chi) > GRID_COLS - 1) ? 5'(GRID_COLS - 1) : chi[4:0];
              r_nxt = (br_nxt >= 5'(c_r.radius)) ? br_nxt - 5'(c_r.radius) : '0;
              c0_nxt = (bc_nxt >= 5'(c_r.radius)) ? bc_nxt - 5'(c_r.radius) : '0;
              c2_nxt = c0_nxt;
              st_nxt = BK_TRN_RD;
            end
            CMD_COUNT: st_nxt = BK_CNT_RD;
            default:   st_nxt = BK_OUT;
          endcase
        end else begin
          fn_nxt = fn_r + 1'b1;
          if (32'(c2_r) == GRID_COLS - 1) begin
            c2_nxt = '0; r_nxt = r_r + 1'b1;
          end else c2_nxt = c2_r + 1'b1;
          st_nxt = BK_SRCH;
        end
      end
      BK_TRN_RD: st_nxt = BK_TRN_MUL;
      BK_TRN_MUL: st_nxt = BK_TRN_WR;
      BK_TRN_WR: begin
        we = 1'b1;
        wnew = (wsum > 18'sd32767) ? 16'sh7fff :
               (wsum < -18'sd32768) ? 16'sh8000 : 16'(wsum);
        st_nxt = BK_TRN_RD;
        if (32'(e_r) == VECTOR_LEN - 1) begin
          e_nxt = '0;
          if (c2_r == c1_r) begin
            c2_nxt = c0_r;
            if (r_r == r1_r) st_nxt = BK_OUT;
            else r_nxt = r_r + 1'b1;
          end else c2_nxt = c2_r + 1'b1;
        end else e_nxt = e_r + 1'b1;
      end
      BK_CNT_RD: st_nxt = BK_CNT_WR;
      BK_CNT_WR: begin
        cwe = 1'b1;
        cval_nxt[bn_r] = 1'b1;
        st_nxt = BK_OUT;
      end
      BK_FIN: begin
        lab_nxt[fn_r] = cval_r[fn_r] && (k1_r > k0_r);
        if (32'(fn_r) == NEUR - 1) begin
          cval_nxt = '0; st_nxt = BK_IDLE;
        end else fn_nxt = fn_r + 1'b1;
      end
      // load the output register only once the previous word has left
      BK_OUT: if (!ov_r || !out_stall) begin
        ov_nxt = 1'b1; st_nxt = BK_IDLE;
        ow_nxt.winner_row = br_r[2:0];
        ow_nxt.winner_col = bc_r[2:0];
        ow_nxt.min_distance = bd_r;
        ow_nxt.label = 1'b0;
        case (c_r.op)
          CMD_TRAIN: ow_nxt.result_kind = KIND_TRAIN;
          CMD_COUNT: ow_nxt.result_kind = KIND_COUNT;
          default: begin
            ow_nxt.result_kind = KIND_CLASSIFY;
            ow_nxt.label = lab_r[bn_r];
          end
        endcase
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE; ov_r <= 1'b0; lab_r <= '0; cval_r <= '0;
      fn_r <= '0; e_r <= '0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt; lab_r <= lab_nxt; cval_r <= cval_nxt;
      fn_r <= fn_nxt; e_r <= e_nxt;
    end
    c_r <= c_nxt; r_r <= r_nxt; c2_r <= c2_nxt; r1_r <= r1_nxt; c0_r <= c0_nxt;
    c1_r <= c1_nxt; bn_r <= bn_nxt; d_r <= d_nxt; bd_r <= bd_nxt; ow_r <= ow_nxt;
    br_r <= br_nxt; bc_r <= bc_nxt;
  end

  // Weight memory: one write port, one read port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      if (st_r == BK_IDLE)
        wmem[WAW'(32'(q_head.row) * GRID_COLS * VECTOR_LEN + 32'(q_head.col) * VECTOR_LEN
             + 32'(q_head.eidx))] <= wnew;
      else wmem[waddr] <= wnew;
    end
    wq_r <= wmem[waddr];
    pq_r <= pat_rdata;
    prod_r <= 34'(signed'({1'b0, c_r.rate})) * 34'(diff);
  end

  // Counter read address: first neuron ahead of finalize, the winner after a search
  always_comb begin
    if (st_r == BK_IDLE) kidx = '0;
    else if (st_r == BK_DECIDE) kidx = bn_nxt;
    else if (st_r == BK_FIN) kidx = fn_nxt;
    else kidx = bn_r;
  end

  // Class counters: read, bump with saturation, write back
  always_ff @(posedge clk) begin
    k0_r <= cval_r[kidx] ? cnt0[kidx] : 16'd0;
    k1_r <= cval_r[kidx] ? cnt1[kidx] : 16'd0;
    if (cwe) begin
      cnt0[bn_r] <= (!c_r.class_bit && k0_r != 16'hffff) ? k0_r + 16'd1 : k0_r;
      cnt1[bn_r] <= (c_r.class_bit && k1_r != 16'hffff) ? k1_r + 16'd1 : k1_r;
    end
  end
endmodule
